/* src/assert_macros.svh */
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/kls_pkg.sv */
package kls_pkg;
	localparam int DEPTH  = 64;
	localparam int VAL_W  = 32;
	localparam int K_W    = 7;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int KE_W   = (FILL_W > K_W) ? FILL_W : K_W;

	typedef logic signed [VAL_W-1:0] value_t;

	// Row-wide command for one accepted transaction
	typedef struct packed {
		logic shift_in;  // insert the sample at its sorted place
		logic drop_min;  // drop the minimum and insert the sample
	} kls_ctl_t;
endpackage

/* src/kls_if.sv */
interface kls_in_if;
	import kls_pkg::*;
	logic   valid;
	logic   ready;
	value_t sample_value;
	logic   last_item;

	modport source (output valid, output sample_value, output last_item, input ready);
	modport sink (input valid, input sample_value, input last_item, output ready);
endinterface

interface kls_out_if;
	import kls_pkg::*;
	logic   valid;
	logic   ready;
	value_t kth_value;
	logic   enough_items;

	modport source (output valid, output kth_value, output enough_items, input ready);
	modport sink (input valid, input kth_value, input enough_items, output ready);
endinterface

/* src/kls_cell.sv */
module kls_cell (
	input  logic              clk,
	input  kls_pkg::kls_ctl_t ctl,
	input  kls_pkg::value_t   sample,
	input  logic              in_use,
	input  kls_pkg::value_t   prev_value,
	input  logic              prev_lt,
	input  kls_pkg::value_t   next_value,
	input  logic              next_lt,
	output logic              lt,
	output kls_pkg::value_t   value_q,
	output kls_pkg::value_t   value_d
);
	import kls_pkg::*;

	// The row is kept in ascending order; lt marks a live entry below the sample
	assign lt = in_use && (value_q < sample);

	always_comb begin
		value_d = value_q;
		if (ctl.shift_in) begin
			// hold smaller entries, take the sample at the boundary, shift up above it
			if (lt) begin
				value_d = value_q;
			end else if (prev_lt) begin
				value_d = sample;
			end else begin
				value_d = prev_value;
			end
		end else if (ctl.drop_min) begin
			// shift down below the sample's place, take it at the boundary
			if (next_lt) begin
				value_d = next_value;
			end else if (lt) begin
				value_d = sample;
			end else begin
				value_d = value_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end
endmodule

/* src/kth_largest_stream_select.sv */
// Streaming k-th largest selector.
// samples: one signed 32-bit value per transaction; last_item closes a set.
// results: one transaction per set, sent after its last item, carrying the
//   k-th largest value of the set and enough_items (0 with a zero value when
//   fewer than k items arrived).
// k_count: write k_count_we with k_count_wdata while idle; 0 acts as 1 and
//   values above the row length act as the row length.
// Throughput: one sample per cycle while samples.ready is high. A sorted row of
//   DEPTH cells takes each sample by shifting its neighbours one place.
// Output: the result is registered and valid in the cycle after the last item is taken.
// Stall: the result waits in an output register and holds samples.ready low
//   until it is taken; the next sample is taken while the result is taken.
// Reset: the set is emptied, k_count returns to 1, no result is pending.
module kth_largest_stream_select (
	input  logic                   clk,
	input  logic                   arst_n,
	kls_in_if.sink                 samples,
	kls_out_if.source              results,
	input  logic                   k_count_we,
	input  logic [kls_pkg::K_W-1:0] k_count_wdata
);
	import kls_pkg::*;

	logic [K_W-1:0]    k_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;
	logic [KE_W-1:0]   k_ext;
	logic [KE_W-1:0]   k_eff;
	logic              at_k;
	logic              enough_next;
	logic              accept;
	kls_ctl_t          ctl;

	logic              out_valid_q;
	value_t            kth_q;
	logic              enough_q;

	logic   [DEPTH-1:0] in_use;
	logic   [DEPTH-1:0] lt;
	value_t             cell_q [DEPTH];
	value_t             cell_d [DEPTH];

	assign k_ext = KE_W'(k_q);
	assign k_eff = (k_ext == '0) ? KE_W'(1) :
		((k_ext > KE_W'(DEPTH)) ? KE_W'(DEPTH) : k_ext);
	assign at_k  = KE_W'(fill_q) >= k_eff;

	assign samples.ready = !out_valid_q || results.ready;
	assign accept        = samples.valid && samples.ready;

	assign ctl.shift_in = accept && !at_k;
	assign ctl.drop_min = accept && at_k && lt[0];

	assign fill_next   = ctl.shift_in ? fill_q + FILL_W'(1) : fill_q;
	assign enough_next = KE_W'(fill_next) >= k_eff;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			value_t prev_v;
			logic   prev_l;
			value_t next_v;
			logic   next_l;

			assign in_use[i] = FILL_W'(i) < fill_q;

			if (i == 0) begin : g_head
				assign prev_v = samples.sample_value;
				assign prev_l = 1'b1;
			end else begin : g_body
				assign prev_v = cell_q[i-1];
				assign prev_l = lt[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign next_v = cell_q[i];
				assign next_l = 1'b0;
			end else begin : g_link
				assign next_v = cell_q[i+1];
				assign next_l = lt[i+1];
			end

			kls_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.sample     (samples.sample_value),
				.in_use     (in_use[i]),
				.prev_value (prev_v),
				.prev_lt    (prev_l),
				.next_value (next_v),
				.next_lt    (next_l),
				.lt         (lt[i]),
				.value_q    (cell_q[i]),
				.value_d    (cell_d[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= K_W'(1);
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (k_count_we) begin
				k_q <= k_count_wdata;
			end
			if (accept) begin
				fill_q <= samples.last_item ? '0 : fill_next;
			end
			if (accept && samples.last_item) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Minimum sits in the first cell once the transaction is applied
	always_ff @(posedge clk) begin
		if (accept && samples.last_item) begin
			kth_q    <= enough_next ? cell_d[0] : '0;
			enough_q <= enough_next;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.kth_value    = kth_q;
	assign results.enough_items = enough_q;
endmodule

/* src/kls_checker.sv */
`include "assert_macros.svh"

module kls_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                in_last,
	input logic                out_valid,
	input logic                out_ready,
	input kls_pkg::value_t     out_kth,
	input logic                out_enough
);
	import kls_pkg::*;

	// A pending result holds until taken
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_kth))
	// Every closing transaction yields a result next cycle
	`ASSERT_NEXT(a_last_gives_result, clk, arst_n, in_valid && in_ready && in_last, out_valid)
	// A new result only follows a closing transaction
	`ASSERT_IMPL(a_no_spurious, clk, arst_n, $rose(out_valid),
		$past(in_valid && in_ready && in_last))
	// Short sets report zero
	`ASSERT_IMPL(a_short_zero, clk, arst_n, out_valid && !out_enough, out_kth == '0)
endmodule

bind kth_largest_stream_select kls_checker u_kls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.in_last    (samples.last_item),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_kth    (results.kth_value),
	.out_enough (results.enough_items)
);
